// ----- design/bsfs_pkg.sv -----
// Shared types, constants and word functions of the bitmap store.
// Used by bsfs_ctrl, bsfs_datapath and bitmap_store_find_set_unit.
`timescale 1ns / 1ps
`default_nettype none
package bsfs_pkg;

   localparam int MAX_BITS   = 4096;
   localparam int WORD_BITS  = 64;
   localparam int WORD_COUNT = MAX_BITS / WORD_BITS;
   localparam int IDX_W      = $clog2(WORD_COUNT);
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int SIZE_W     = 13;
   localparam int POS_W      = 16;
   localparam int OP_W       = 4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_BITS);
   localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 4'd0,
      OP_SETALL = 4'd1,
      OP_INVERT = 4'd2,
      OP_WRITE  = 4'd3,
      OP_FLIP   = 4'd4,
      OP_TEST   = 4'd5,
      OP_ANY    = 4'd6,
      OP_ALL    = 4'd7,
      OP_COUNT  = 4'd8,
      OP_NEXT   = 4'd9,
      OP_PREV   = 4'd10,
      OP_SHL    = 4'd11,
      OP_SHR    = 4'd12
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic             accept;
      logic             issue;
      logic [IDX_W-1:0] idx;
      logic             load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic             skip;
      logic             trim;
      logic             down;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] last;
   } plan_type;

   // Lowest set bit; 63 when the word is zero.
   function automatic logic [OFF_W-1:0] low_index(input logic [WORD_BITS-1:0] w);
      logic [OFF_W-1:0] r;
      r = OFF_W'(WORD_BITS - 1);
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
         if (w[k]) r = OFF_W'(k);
      end
      return r;
   endfunction

   // Highest set bit; 0 when the word is zero.
   function automatic logic [OFF_W-1:0] high_index(input logic [WORD_BITS-1:0] w);
      logic [OFF_W-1:0] r;
      r = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
         if (w[k]) r = OFF_W'(k);
      end
      return r;
   endfunction

   function automatic logic [OFF_W:0] pop_count(input logic [WORD_BITS-1:0] w);
      logic [OFF_W:0] c;
      c = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
         c = c + (OFF_W+1)'(w[k]);
      end
      return c;
   endfunction

   // Bits of word i that lie below size n.
   function automatic logic [WORD_BITS-1:0] word_mask(input logic [IDX_W-1:0] i,
                                                      input logic [SIZE_W-1:0] n);
      logic [SIZE_W-OFF_W-1:0] full;
      logic [SIZE_W-OFF_W-1:0] iw;
      logic [WORD_BITS-1:0]    m;
      full = n[SIZE_W-1:OFF_W];
      iw   = (SIZE_W-OFF_W)'(i);
      if (iw < full) m = ALL_ONES;
      else if (iw == full) m = ~(ALL_ONES << n[OFF_W-1:0]);
      else m = '0;
      return m;
   endfunction

endpackage
`default_nettype wire

// ----- design/bitmap_store_find_set_unit.sv -----
// Top level of the bitmap store with find next / previous set bit.
// Depends on bsfs_pkg; instantiates bsfs_ctrl and bsfs_datapath.
//
// Usage: one request on req_* (operation, position, bit_value, shift_amount)
// gives one response on rsp_* (result_value, status). Both channels hand over
// a request or response at a clock edge with valid high and stall low.
// csr_we with csr_wdata sets the size in use; write it only while no request is
// in flight. A size write rewrites the whole store, during which req_stall is
// high.
// Work per request: requests that touch no word (clear, out-of-range bit
// operations, failed-early finds, unused codes) go straight from planning to
// the answer. Bit write, flip and test sweep one word. Set all, invert, any,
// all, count and both shifts sweep all 64 words, one per cycle through the
// word memory; finds sweep from the start word to the end.
// One request is worked on at a time; the next is taken once the response sits
// in the output register, even while the receiver stalls it.
// Reset: store reads as all zero, size is 4096, no response pending.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_store_find_set_unit (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [bsfs_pkg::OP_W-1:0]    req_operation,
   input  wire [bsfs_pkg::POS_W-1:0]   req_position,
   input  wire                         req_bit_value,
   input  wire [bsfs_pkg::POS_W-1:0]   req_shift_amount,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [bsfs_pkg::SIZE_W-1:0] rsp_result_value,
   output logic                        rsp_status,
   input  wire                         csr_we,
   input  wire [bsfs_pkg::SIZE_W-1:0]  csr_wdata
);
   import bsfs_pkg::*;

   ctl_cmd_type cmd;
   plan_type    plan;

   bsfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .plan      (plan),
      .cmd       (cmd)
   );

   bsfs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_bit_value    (req_bit_value),
      .req_shift_amount (req_shift_amount),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .plan             (plan),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule
`default_nettype wire

// ----- design/bsfs_ctrl.sv -----
// Controller of the bitmap store: handshakes, job planning and word sweep counter.
// Depends on bsfs_pkg; drives bsfs_datapath through a command struct.
`timescale 1ns / 1ps
`default_nettype none
module bsfs_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   input  wire                 csr_we,
   input  bsfs_pkg::plan_type  plan,
   output bsfs_pkg::ctl_cmd_type cmd
);
   import bsfs_pkg::*;

   ctl_state_type    state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      cmd.idx    = cnt_ff;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = csr_we;
            if (csr_we) begin
               state_in = ST_PLAN;
            end else if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PLAN;
            end
         end
         ST_PLAN: begin
            cnt_in = plan.first;
            if (plan.skip) state_in = ST_FINISH;
            else state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.issue = 1'b1;
            if (cnt_ff == plan.last) state_in = ST_DRAIN;
            else if (plan.down) cnt_in = cnt_ff - IDX_W'(1);
            else cnt_in = cnt_ff + IDX_W'(1);
         end
         ST_DRAIN: begin
            // a size update rewrites the store and answers nothing
            if (plan.trim) state_in = ST_IDLE;
            else state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- design/bsfs_datapath.sv -----
// Datapath of the bitmap store: size register, word memory, sweep stage and result.
// Depends on bsfs_pkg; steered by bsfs_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module bsfs_datapath (
   input  wire                         clock,
   input  wire                         reset,
   input  wire [bsfs_pkg::OP_W-1:0]    req_operation,
   input  wire [bsfs_pkg::POS_W-1:0]   req_position,
   input  wire                         req_bit_value,
   input  wire [bsfs_pkg::POS_W-1:0]   req_shift_amount,
   input  wire                         csr_we,
   input  wire [bsfs_pkg::SIZE_W-1:0]  csr_wdata,
   input  bsfs_pkg::ctl_cmd_type       cmd,
   output bsfs_pkg::plan_type          plan,
   output logic [bsfs_pkg::SIZE_W-1:0] rsp_result_value,
   output logic                        rsp_status
);
   import bsfs_pkg::*;

   localparam int SW_W = POS_W - OFF_W;
   localparam int AD_W = SW_W + 1;

   logic [SIZE_W-1:0]    size_ff;
   op_type               op_ff;
   logic                 trim_ff;
   logic [POS_W-1:0]     pos_ff;
   logic                 val_ff;
   logic [POS_W-1:0]     sh_ff;

   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff, valid_in;
   logic [WORD_BITS-1:0] mem_a_ff, mem_b_ff;
   logic                 va_ff, vb_ff;

   logic                 s1_ff;
   logic [IDX_W-1:0]     idx1_ff;

   logic [SIZE_W-1:0]    acc_ff, acc_in;
   logic                 flag_ff, flag_in;
   logic                 found_ff, found_in;
   logic [SIZE_W-1:0]    res_ff, res_in;
   logic                 st_ff, st_in;

   logic [SIZE_W-1:0]    n;
   logic [SIZE_W-1:0]    nm1;
   logic                 oor;
   logic [OFF_W*2-1:0]   pe;
   logic [OFF_W-1:0]     sb;
   logic [SW_W-1:0]      sw;
   logic [AD_W-1:0]      da, db;
   logic                 oka, okb;
   logic [WORD_BITS-1:0] rda, rdb;
   logic [WORD_BITS-1:0] wmask, bitm, fmask, fw, wdata;
   logic                 we;
   logic [OFF_W:0]       pc;

   assign n   = (size_ff > SIZE_RESET) ? SIZE_RESET : size_ff;
   assign nm1 = n - SIZE_W'(1);
   assign oor = pos_ff >= POS_W'(n);
   assign pe  = oor ? nm1[OFF_W*2-1:0] : pos_ff[OFF_W*2-1:0];
   assign sb  = sh_ff[OFF_W-1:0];
   assign sw  = sh_ff[POS_W-1:OFF_W];

   // request and size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         trim_ff <= 1'b0;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
         trim_ff <= 1'b1;
      end else if (cmd.accept) begin
         trim_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= op_type'(req_operation);
         pos_ff <= req_position;
         val_ff <= req_bit_value;
         sh_ff  <= req_shift_amount;
      end
   end

   // job plan: which words to sweep and in which direction
   always_comb begin
      plan       = '0;
      plan.trim  = trim_ff;
      plan.last  = IDX_W'(WORD_COUNT - 1);
      if (trim_ff) begin
         plan.first = '0;
      end else begin
         case (op_ff)
            OP_SETALL, OP_INVERT, OP_ANY, OP_ALL, OP_COUNT, OP_SHR: plan.first = '0;
            OP_SHL: begin
               plan.down  = 1'b1;
               plan.first = IDX_W'(WORD_COUNT - 1);
               plan.last  = '0;
            end
            OP_WRITE, OP_FLIP, OP_TEST: begin
               plan.skip  = oor;
               plan.first = pos_ff[OFF_W+IDX_W-1:OFF_W];
               plan.last  = pos_ff[OFF_W+IDX_W-1:OFF_W];
            end
            OP_NEXT: begin
               plan.skip  = oor;
               plan.first = pos_ff[OFF_W+IDX_W-1:OFF_W];
            end
            OP_PREV: begin
               plan.skip  = (n == '0);
               plan.down  = 1'b1;
               plan.first = pe[OFF_W+IDX_W-1:OFF_W];
               plan.last  = '0;
            end
            default: plan.skip = 1'b1;
         endcase
      end
   end

   // read addresses: shifts read two neighboring source words
   always_comb begin
      da  = AD_W'(cmd.idx);
      db  = da;
      oka = 1'b1;
      okb = 1'b0;
      if (!trim_ff && op_ff == OP_SHL) begin
         da  = AD_W'(cmd.idx) - AD_W'(sw);
         db  = da - AD_W'(1);
         oka = !da[AD_W-1];
         okb = !db[AD_W-1];
      end else if (!trim_ff && op_ff == OP_SHR) begin
         da  = AD_W'(cmd.idx) + AD_W'(sw);
         db  = da + AD_W'(1);
         oka = (da[AD_W-1:IDX_W] == '0);
         okb = (db[AD_W-1:IDX_W] == '0);
      end
   end

   always_ff @(posedge clock) begin
      mem_a_ff <= mem[da[IDX_W-1:0]];
      mem_b_ff <= mem[db[IDX_W-1:0]];
      if (we) mem[idx1_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         s1_ff    <= 1'b0;
         idx1_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         va_ff    <= oka & valid_ff[da[IDX_W-1:0]];
         vb_ff    <= okb & valid_ff[db[IDX_W-1:0]];
         s1_ff    <= cmd.issue;
         idx1_ff  <= cmd.idx;
      end
   end

   assign rda = va_ff ? mem_a_ff : '0;
   assign rdb = vb_ff ? mem_b_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.accept && op_type'(req_operation) == OP_CLEAR) valid_in = '0;
      else if (we) valid_in[idx1_ff] = 1'b1;
   end

   // sweep stage: new word contents and scan accumulation
   always_comb begin
      wmask = word_mask(idx1_ff, n);
      bitm  = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos_ff[OFF_W-1:0];
      fmask = ALL_ONES;
      if (idx1_ff == plan.first) begin
         if (op_ff == OP_PREV) fmask = ALL_ONES >> (OFF_W'(WORD_BITS - 1) - pe[OFF_W-1:0]);
         else fmask = ALL_ONES << pos_ff[OFF_W-1:0];
      end
      fw    = rda & fmask;
      pc    = pop_count(rda);
      we    = 1'b0;
      wdata = rda;
      if (s1_ff) begin
         if (trim_ff) begin
            we = 1'b1;
         end else begin
            case (op_ff)
               OP_SETALL: begin
                  we    = 1'b1;
                  wdata = ALL_ONES;
               end
               OP_INVERT: begin
                  we    = 1'b1;
                  wdata = ~rda;
               end
               OP_WRITE: begin
                  we    = 1'b1;
                  wdata = val_ff ? (rda | bitm) : (rda & ~bitm);
               end
               OP_FLIP: begin
                  we    = 1'b1;
                  wdata = rda ^ bitm;
               end
               OP_SHL: begin
                  we = 1'b1;
                  if (sb != '0)
                     wdata = (rda << sb) | (rdb >> ((OFF_W+1)'(WORD_BITS) - (OFF_W+1)'(sb)));
               end
               OP_SHR: begin
                  we = 1'b1;
                  if (sb != '0)
                     wdata = (rda >> sb) | (rdb << ((OFF_W+1)'(WORD_BITS) - (OFF_W+1)'(sb)));
               end
               default: we = 1'b0;
            endcase
         end
      end
      wdata = wdata & wmask;
   end

   always_comb begin
      acc_in   = acc_ff;
      flag_in  = flag_ff;
      found_in = found_ff;
      if (cmd.accept || csr_we) begin
         acc_in   = '0;
         flag_in  = 1'b0;
         found_in = 1'b0;
      end else if (s1_ff && !trim_ff) begin
         case (op_ff)
            OP_TEST:  acc_in = SIZE_W'(rda[pos_ff[OFF_W-1:0]]);
            OP_ANY:   if (rda != '0) flag_in = 1'b1;
            OP_ALL:   if (rda != wmask) flag_in = 1'b1;
            OP_COUNT: acc_in = acc_ff + SIZE_W'(pc);
            OP_NEXT: begin
               if (!found_ff && fw != '0) begin
                  found_in = 1'b1;
                  acc_in   = SIZE_W'({idx1_ff, low_index(fw)});
               end
            end
            OP_PREV: begin
               if (!found_ff && fw != '0) begin
                  found_in = 1'b1;
                  acc_in   = SIZE_W'({idx1_ff, high_index(fw)});
               end
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         flag_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         flag_ff  <= flag_in;
         found_ff <= found_in;
      end
   end

   // result
   always_comb begin
      res_in = '0;
      st_in  = 1'b0;
      case (op_ff)
         OP_WRITE, OP_FLIP: st_in = oor;
         OP_TEST: begin
            st_in = oor;
            if (!oor) res_in = acc_ff;
         end
         OP_ANY:   res_in = SIZE_W'(flag_ff);
         OP_ALL:   res_in = SIZE_W'(!flag_ff);
         OP_COUNT: res_in = acc_ff;
         OP_NEXT, OP_PREV: res_in = found_ff ? acc_ff : n;
         default:  res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         res_ff <= res_in;
         st_ff  <= st_in;
      end
   end

   assign rsp_result_value = res_ff;
   assign rsp_status       = st_ff;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for bitmap_store_find_set_unit: random and directed requests
// against a bitmap predictor kept in a small scoreboard class.
// Depends on bsfs_pkg for widths and operation codes.
`timescale 1ns / 1ps
module testbench;
   import bsfs_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd13;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [SIZE_W-1:0] value;
      logic              status;
   } answer_type;

   class scoreboard_type;
      logic [WORD_BITS-1:0] words[WORD_COUNT];
      int size_reg;
      answer_type pending[$];
      int errors;

      function void clear_store();
         foreach (words[i]) words[i] = '0;
      endfunction

      function void init();
         clear_store();
         size_reg = MAX_BITS;
         errors = 0;
      endfunction

      function int used_bits();
         return size_reg > MAX_BITS ? MAX_BITS : size_reg;
      endfunction

      function int used_words();
         return (used_bits() + WORD_BITS - 1) / WORD_BITS;
      endfunction

      function logic [WORD_BITS-1:0] live_mask(int i);
         int n;
         n = used_bits();
         if (i < n / WORD_BITS) return '1;
         if (i == n / WORD_BITS) return ~({WORD_BITS{1'b1}} << (n % WORD_BITS));
         return '0;
      endfunction

      function void trim();
         foreach (words[i]) words[i] &= live_mask(i);
      endfunction

      function void set_size(logic [SIZE_W-1:0] v);
         size_reg = v;
         trim();
      endfunction

      function int lowest(logic [WORD_BITS-1:0] w);
         for (int k = 0; k < WORD_BITS; k++) if (w[k]) return k;
         return WORD_BITS - 1;
      endfunction

      function int highest(logic [WORD_BITS-1:0] w);
         for (int k = WORD_BITS - 1; k >= 0; k--) if (w[k]) return k;
         return 0;
      endfunction

      function void shift_up(int sh);
         int nw, sw, sb;
         logic [WORD_BITS-1:0] hi, lo;
         nw = used_words(); sw = sh / WORD_BITS; sb = sh % WORD_BITS;
         if (sh == 0 || used_bits() == 0) return;
         if (sw >= nw) begin
            clear_store();
            return;
         end
         for (int i = nw - 1; i >= sw; i--) begin
            hi = words[i-sw] << sb;
            lo = (sb != 0 && i - sw > 0) ? words[i-sw-1] >> (WORD_BITS - sb) : '0;
            words[i] = hi | lo;
         end
         for (int i = 0; i < sw; i++) words[i] = '0;
         trim();
      endfunction

      function void shift_down(int sh);
         int nw, sw, sb;
         logic [WORD_BITS-1:0] hi, lo;
         nw = used_words(); sw = sh / WORD_BITS; sb = sh % WORD_BITS;
         if (sh == 0 || used_bits() == 0) return;
         if (sw >= nw) begin
            clear_store();
            return;
         end
         for (int i = 0; i + sw < nw; i++) begin
            lo = words[i+sw] >> sb;
            hi = (sb != 0 && i + sw + 1 < nw) ? words[i+sw+1] << (WORD_BITS - sb) : '0;
            words[i] = lo | hi;
         end
         for (int i = nw - sw; i < nw; i++) words[i] = '0;
         trim();
      endfunction

      function int next_set(int pos);
         int n, id;
         logic [WORD_BITS-1:0] w;
         n = used_bits();
         if (pos >= n) return n;
         id = pos / WORD_BITS;
         w = words[id] & ({WORD_BITS{1'b1}} << (pos % WORD_BITS));
         if (w != 0) return id * WORD_BITS + lowest(w);
         for (id = id + 1; id < used_words(); id++)
            if (words[id] != 0) return id * WORD_BITS + lowest(words[id]);
         return n;
      endfunction

      function int prev_set(int pos);
         int n, id, off;
         logic [WORD_BITS-1:0] w;
         n = used_bits();
         if (n == 0) return 0;
         if (pos >= n) pos = n - 1;
         id = pos / WORD_BITS; off = pos % WORD_BITS;
         w = words[id] & ((off == WORD_BITS - 1) ? {WORD_BITS{1'b1}}
                          : ~({WORD_BITS{1'b1}} << (off + 1)));
         if (w != 0) return id * WORD_BITS + highest(w);
         while (id > 0) begin
            id--;
            if (words[id] != 0) return id * WORD_BITS + highest(words[id]);
         end
         return n;
      endfunction

      // Apply one accepted request and queue the answer it must produce.
      function void note_request(logic [OP_W-1:0] op, int pos, logic bval, int sh);
         int n, nw, res, wi;
         logic st;
         answer_type a;
         n = used_bits(); nw = used_words(); res = 0; st = 0;
         wi = (pos / WORD_BITS) % WORD_COUNT;
         case (op)
            OP_CLEAR: clear_store();
            OP_SETALL: begin
               foreach (words[i]) words[i] = '1;
               trim();
            end
            OP_INVERT: begin
               foreach (words[i]) words[i] = ~words[i];
               trim();
            end
            OP_WRITE, OP_FLIP, OP_TEST: begin
               if (pos >= n) st = 1;
               else if (op == OP_WRITE) words[wi][pos % WORD_BITS] = bval;
               else if (op == OP_FLIP) words[wi][pos % WORD_BITS] ^= 1'b1;
               else res = words[wi][pos % WORD_BITS];
            end
            OP_ANY: for (int i = 0; i < nw; i++) if (words[i] != 0) res = 1;
            OP_ALL: begin
               res = 1;
               for (int i = 0; i < nw; i++) if (words[i] != live_mask(i)) res = 0;
            end
            OP_COUNT: for (int i = 0; i < nw; i++) res += $countones(words[i]);
            OP_NEXT: res = next_set(pos);
            OP_PREV: res = prev_set(pos);
            OP_SHL: shift_up(sh);
            OP_SHR: shift_down(sh);
            default: ;
         endcase
         a.value = res[SIZE_W-1:0];
         a.status = st;
         pending = {pending, a};
      endfunction

      function void check_response(logic [SIZE_W-1:0] value, logic status);
         answer_type a;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual value=%0d status=%0d",
                     $time, value, status);
            errors++;
            return;
         end
         a = pending.pop_front();
         if (value !== a.value) begin
            $display("%0t: result_value expected %0d actual %0d", $time, a.value, value);
            errors++;
         end
         if (status !== a.status) begin
            $display("%0t: status expected %0d actual %0d", $time, a.status, status);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, req_bit_value;
   logic [OP_W-1:0] req_operation;
   logic [POS_W-1:0] req_position, req_shift_amount;
   logic rsp_valid, rsp_stall, rsp_status;
   logic [SIZE_W-1:0] rsp_result_value;
   logic csr_we;
   logic [SIZE_W-1:0] csr_wdata;

   scoreboard_type sb;
   int cycles;
   bit quiet;        // no gaps on either side
   bit hold_request; // ask the receiver for a long hold-off
   int hold_left, stall_left;

   bitmap_store_find_set_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_position(req_position),
      .req_bit_value(req_bit_value), .req_shift_amount(req_shift_amount),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Response side: check, then stall at random or for a long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_result_value, rsp_status);
            stall_left = quiet ? 0 : $urandom_range(0, 6);
         end
         if (hold_request) begin
            hold_request = 0;
            hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send(logic [OP_W-1:0] op, int pos, logic bval, int sh);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_position <= pos[POS_W-1:0];
      req_bit_value <= bval;
      req_shift_amount <= sh[POS_W-1:0];
      do @(posedge clock); while (req_stall);
      sb.note_request(op, pos & 16'hFFFF, bval, sh & 16'hFFFF);
   endtask

   // Drain every request, let the block settle, then write the size.
   task automatic write_size(logic [SIZE_W-1:0] v);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_size(v);
      csr_we <= 1'b0;
   endtask

   task automatic send_random();
      logic [OP_W-1:0] op;
      int n, pos, sh, r;
      n = sb.used_bits();
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else if (r < 30) op = OP_W'($urandom_range(OP_WRITE, OP_FLIP));
      else op = OP_W'($urandom_range(OP_CLEAR, OP_SHR));
      r = $urandom_range(0, 9);
      if (r < 6) pos = $urandom_range(0, n + 2);
      else if (r < 7) pos = n + $urandom_range(0, 2) - 1;
      else pos = $urandom_range(0, 65535);
      if (pos < 0) pos = 0;
      r = $urandom_range(0, 9);
      if (r < 5) sh = $urandom_range(0, n + 64);
      else if (r < 7) sh = $urandom_range(0, 63);
      else sh = $urandom_range(0, 65535);
      send(op, pos, 1'($urandom_range(0, 1)), sh);
   endtask

   initial begin
      int sizes[10];
      sb = new();
      sb.init();
      cycles = 0; quiet = 0; hold_request = 0; hold_left = 0; stall_left = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_operation = '0; req_position = '0;
      req_bit_value = 1'b0; req_shift_amount = '0;
      csr_we = 1'b0; csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send(OP_ANY, 0, 0, 0);
      send(OP_ALL, 0, 0, 0);
      send(OP_SETALL, 0, 0, 0);
      send(OP_ALL, 0, 0, 0);
      send(OP_COUNT, 0, 0, 0);
      send(OP_WRITE, 4095, 0, 0);
      send(OP_WRITE, 0, 0, 0);
      send(OP_NEXT, 0, 0, 0);
      send(OP_PREV, 65535, 0, 0);
      send(OP_TEST, 4096, 1, 0);
      send(OP_FLIP, 65535, 0, 0);
      send(OP_WRITE, 65535, 1, 0);
      send(OP_SHL, 0, 0, 1);
      send(OP_SHR, 0, 0, 4095);
      send(OP_INVERT, 0, 0, 0);
      send(OP_COUNT, 0, 0, 0);
      send(OP_PREV, 0, 0, 0);
      send(OP_NEXT, 65535, 0, 0);
      send(OP_SHR, 0, 0, 65535);
      send(OP_SHL, 0, 0, 0);
      send(OP_ANY, 0, 0, 0);
      send(OP_CLEAR, 0, 0, 0);
      send(OP_SPARE_FIRST, 65535, 1, 65535);
      send(OP_SPARE_LAST, 0, 0, 0);

      sizes = '{0, 1, 8191, 63, 64, 65, 4095, 700, 4096, 0};
      sizes[9] = $urandom_range(0, 8191);
      foreach (sizes[p]) begin
         write_size(sizes[p][SIZE_W-1:0]);
         quiet = (p % 3 == 2);
         if (sizes[p] == 0) begin
            // empty map: the special cases of size zero
            send(OP_ANY, 0, 0, 0);
            send(OP_ALL, 0, 0, 0);
            send(OP_PREV, 5, 0, 0);
            send(OP_NEXT, 0, 0, 0);
            send(OP_SHL, 0, 0, 3);
         end
         if (p == 4) hold_request = 1;
         repeat (180) send_random();
      end

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end
endmodule

// ----- filelist.f -----
design/bsfs_pkg.sv
design/bsfs_ctrl.sv
design/bsfs_datapath.sv
design/bitmap_store_find_set_unit.sv
bench/testbench.sv
